// ===== sv/rmj_pkg.sv =====
// Shared constants and types for the radar measurement Jacobian pipeline.
// No dependencies; imported by rmj_sqrt, rmj_div and radar_measurement_jacobian.
package rmj_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int R2_W       = 2 * DATA_W;
   localparam int R_W        = DATA_W;
   localparam int R3_W       = R2_W + R_W;
   localparam int CROSS_W    = 2 * DATA_W;
   localparam int NUM_W      = DATA_W + CROSS_W + FRAC_BITS;
   localparam int DEN_W      = R3_W;
   localparam int QUO_W      = DATA_W;
   localparam int LANES      = 6;
   localparam int SQRT_STEPS = R2_W / 2;

   localparam logic [DATA_W-1:0] GUARD_RESET = DATA_W'(429497);
   localparam logic [R2_W-1:0]   R2_ONE      = R2_W'(1) << (2 * FRAC_BITS);

   typedef logic [DATA_W-1:0] word_type;
   typedef logic [NUM_W-1:0]  num_type;
   typedef logic [DEN_W-1:0]  den_type;

   // Values that ride alongside the square root pipeline.
   typedef struct packed {
      logic [DATA_W-1:0] apx;
      logic [DATA_W-1:0] apy;
      logic              px_neg;
      logic              py_neg;
      logic              cneg;
      logic              flag;
      logic [R2_W-1:0]   r2;
      logic [NUM_W-1:0]  nrx;
      logic [NUM_W-1:0]  nry;
   } side_type;

endpackage

// ===== sv/radar_measurement_jacobian.sv =====
// Top level of the radar measurement Jacobian pipeline.
// Depends on rmj_pkg, rmj_sqrt and rmj_div.
//
//   Channel  Direction  Payload (lowest bits first)
//   req      in         tdata: pos_x, pos_y, vel_x, vel_y (32 bits each, Q16.16)
//   rsp      out        tdata: range_by_px, range_by_py, bearing_by_px, bearing_by_py,
//                              rate_by_px, rate_by_py; tuser: near_zero
//   csr      in         wdata: zero_guard (squared range threshold, 2^-32 units)
//
// One word is accepted per clock cycle while the pipeline is not stalled. A word
// passes 73 register stages: five front stages, the 32-stage square root, two
// stages for the cubed range and the 34-stage divider (overflow check, 32 quotient
// bits, saturation). Reset clears every stage valid bit and loads the guard with
// its default of 0.0001. Each stage holds its word while the next stage is full
// and stalled, so empty stages keep filling while a result waits on rsp_tready.
module radar_measurement_jacobian (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [31:0]  csr_wdata,    // zero_guard
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,    // pos_x, pos_y, vel_x, vel_y
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,    // range_by_px, range_by_py, bearing_by_px,
                                      // bearing_by_py, rate_by_px, rate_by_py
   output logic [0:0]   rsp_tuser     // near_zero
);
   import rmj_pkg::*;

   // Configuration register.
   logic [DATA_W-1:0] guard_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff <= GUARD_RESET;
      end else if (csr_wen) begin
         guard_ff <= csr_wdata;
      end
   end

   // Stage 1: split the request and take position magnitudes.
   logic                     s1_vld_ff, en1;
   logic [DATA_W-1:0]        s1_apx_ff, s1_apy_ff;
   logic                     s1_pxn_ff, s1_pyn_ff;
   logic signed [DATA_W-1:0] s1_px_ff, s1_py_ff, s1_vx_ff, s1_vy_ff;
   logic signed [DATA_W-1:0] px_in, py_in;

   assign px_in = req_tdata[DATA_W-1:0];
   assign py_in = req_tdata[2*DATA_W-1:DATA_W];

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_pxn_ff <= px_in[DATA_W-1];
         s1_pyn_ff <= py_in[DATA_W-1];
         s1_apx_ff <= px_in[DATA_W-1] ? DATA_W'(0) - px_in : px_in;
         s1_apy_ff <= py_in[DATA_W-1] ? DATA_W'(0) - py_in : py_in;
         s1_px_ff  <= px_in;
         s1_py_ff  <= py_in;
         s1_vx_ff  <= req_tdata[3*DATA_W-1:2*DATA_W];
         s1_vy_ff  <= req_tdata[4*DATA_W-1:3*DATA_W];
      end
   end

   // Stage 2: squares of the position and the two cross products.
   logic                   s2_vld_ff, en2;
   logic [R2_W-1:0]        s2_sqx_ff, s2_sqy_ff;
   logic signed [R2_W-1:0] s2_a_ff, s2_b_ff;
   logic [DATA_W-1:0]      s2_apx_ff, s2_apy_ff;
   logic                   s2_pxn_ff, s2_pyn_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_sqx_ff <= R2_W'(s1_apx_ff) * R2_W'(s1_apx_ff);
         s2_sqy_ff <= R2_W'(s1_apy_ff) * R2_W'(s1_apy_ff);
         s2_a_ff   <= R2_W'(s1_vx_ff) * R2_W'(s1_py_ff);
         s2_b_ff   <= R2_W'(s1_vy_ff) * R2_W'(s1_px_ff);
         s2_apx_ff <= s1_apx_ff;
         s2_apy_ff <= s1_apy_ff;
         s2_pxn_ff <= s1_pxn_ff;
         s2_pyn_ff <= s1_pyn_ff;
      end
   end

   // Stage 3: squared range and the cross term as sign and magnitude.
   logic               s3_vld_ff, en3;
   logic [R2_W-1:0]    s3_r2_ff;
   logic [CROSS_W-1:0] s3_cmag_ff;
   logic               s3_cneg_ff;
   logic [DATA_W-1:0]  s3_apx_ff, s3_apy_ff;
   logic               s3_pxn_ff, s3_pyn_ff;
   logic               cneg_in;

   assign cneg_in = s2_a_ff < s2_b_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_r2_ff   <= s2_sqx_ff + s2_sqy_ff;
         s3_cneg_ff <= cneg_in;
         s3_cmag_ff <= cneg_in ? CROSS_W'(s2_b_ff - s2_a_ff) : CROSS_W'(s2_a_ff - s2_b_ff);
         s3_apx_ff  <= s2_apx_ff;
         s3_apy_ff  <= s2_apy_ff;
         s3_pxn_ff  <= s2_pxn_ff;
         s3_pyn_ff  <= s2_pyn_ff;
      end
   end

   // Stage 4: near-zero guard and partial products of the rate numerators.
   logic              s4_vld_ff, en4;
   logic [R2_W-1:0]   s4_r2_ff;
   logic              s4_flag_ff;
   logic [R2_W-1:0]   s4_xlo_ff, s4_xhi_ff, s4_ylo_ff, s4_yhi_ff;
   logic [DATA_W-1:0] s4_apx_ff, s4_apy_ff;
   logic              s4_pxn_ff, s4_pyn_ff, s4_cneg_ff;
   logic              near_in;

   assign near_in = s3_r2_ff < R2_W'(guard_ff);

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_flag_ff <= near_in;
         s4_r2_ff   <= near_in ? R2_ONE : s3_r2_ff;
         s4_xlo_ff  <= R2_W'(s3_apx_ff) * R2_W'(s3_cmag_ff[DATA_W-1:0]);
         s4_xhi_ff  <= R2_W'(s3_apx_ff) * R2_W'(s3_cmag_ff[CROSS_W-1:DATA_W]);
         s4_ylo_ff  <= R2_W'(s3_apy_ff) * R2_W'(s3_cmag_ff[DATA_W-1:0]);
         s4_yhi_ff  <= R2_W'(s3_apy_ff) * R2_W'(s3_cmag_ff[CROSS_W-1:DATA_W]);
         s4_apx_ff  <= s3_apx_ff;
         s4_apy_ff  <= s3_apy_ff;
         s4_pxn_ff  <= s3_pxn_ff;
         s4_pyn_ff  <= s3_pyn_ff;
         s4_cneg_ff <= s3_cneg_ff;
      end
   end

   // Stage 5: assemble the rate numerators, already scaled by 2^F.
   logic     s5_vld_ff, en5;
   side_type s5_side_ff;
   side_type side_in;

   always_comb begin
      side_in.apx    = s4_apx_ff;
      side_in.apy    = s4_apy_ff;
      side_in.px_neg = s4_pxn_ff;
      side_in.py_neg = s4_pyn_ff;
      side_in.cneg   = s4_cneg_ff;
      side_in.flag   = s4_flag_ff;
      side_in.r2     = s4_r2_ff;
      side_in.nrx    = (NUM_W'(s4_xhi_ff) << (DATA_W + FRAC_BITS))
                     + (NUM_W'(s4_xlo_ff) << FRAC_BITS);
      side_in.nry    = (NUM_W'(s4_yhi_ff) << (DATA_W + FRAC_BITS))
                     + (NUM_W'(s4_ylo_ff) << FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_side_ff <= side_in;
      end
   end

   // Square root of the (guarded) squared range.
   logic             sq_in_ready, sq_out_valid, en6;
   logic [R_W-1:0]   sq_root;
   side_type         sq_side;

   rmj_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_vld_ff),
      .in_ready  (sq_in_ready),
      .in_r2     (s5_side_ff.r2),
      .in_side   (s5_side_ff),
      .out_valid (sq_out_valid),
      .out_ready (en6),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Stage 6: partial products of the cubed range.
   logic            t6_vld_ff;
   logic [R2_W-1:0] t6_lo_ff, t6_hi_ff;
   logic [R_W-1:0]  t6_r_ff;
   side_type        t6_side_ff;

   always_ff @(posedge clock) begin
      if (en6) begin
         t6_lo_ff   <= R2_W'(sq_side.r2[DATA_W-1:0]) * R2_W'(sq_root);
         t6_hi_ff   <= R2_W'(sq_side.r2[R2_W-1:DATA_W]) * R2_W'(sq_root);
         t6_r_ff    <= sq_root;
         t6_side_ff <= sq_side;
      end
   end

   // Stage 7: cubed range.
   logic           t7_vld_ff, en7;
   logic [R3_W-1:0] t7_r3_ff;
   logic [R_W-1:0]  t7_r_ff;
   side_type        t7_side_ff;

   always_ff @(posedge clock) begin
      if (en7) begin
         t7_r3_ff   <= (R3_W'(t6_hi_ff) << DATA_W) + R3_W'(t6_lo_ff);
         t7_r_ff    <= t6_r_ff;
         t7_side_ff <= t6_side_ff;
      end
   end

   // Divider lanes: range by px and py, bearing by px and py, rate by px and py.
   num_type          div_num [LANES];
   den_type          div_den [LANES];
   logic [LANES-1:0] div_neg;
   logic             div_in_ready, div_out_valid, div_flag;
   word_type         div_quo [LANES];

   always_comb begin
      div_num[0] = NUM_W'(t7_side_ff.apx) << FRAC_BITS;
      div_num[1] = NUM_W'(t7_side_ff.apy) << FRAC_BITS;
      div_num[2] = NUM_W'(t7_side_ff.apy) << (2 * FRAC_BITS);
      div_num[3] = NUM_W'(t7_side_ff.apx) << (2 * FRAC_BITS);
      div_num[4] = t7_side_ff.nry;
      div_num[5] = t7_side_ff.nrx;
      div_den[0] = DEN_W'(t7_r_ff);
      div_den[1] = DEN_W'(t7_r_ff);
      div_den[2] = DEN_W'(t7_side_ff.r2);
      div_den[3] = DEN_W'(t7_side_ff.r2);
      div_den[4] = t7_r3_ff;
      div_den[5] = t7_r3_ff;
      div_neg[0] = t7_side_ff.px_neg;
      div_neg[1] = t7_side_ff.py_neg;
      div_neg[2] = !t7_side_ff.py_neg;
      div_neg[3] = t7_side_ff.px_neg;
      div_neg[4] = t7_side_ff.py_neg ^ t7_side_ff.cneg;
      div_neg[5] = !(t7_side_ff.px_neg ^ t7_side_ff.cneg);
   end

   rmj_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t7_vld_ff),
      .in_ready  (div_in_ready),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_neg    (div_neg),
      .in_flag   (t7_side_ff.flag),
      .out_valid (div_out_valid),
      .out_ready (rsp_tready),
      .out_quo   (div_quo),
      .out_flag  (div_flag)
   );

   // A stage loads when it is empty or when the stage after it moves on.
   assign en7 = !t7_vld_ff || div_in_ready;
   assign en6 = !t6_vld_ff || en7;
   assign en5 = !s5_vld_ff || sq_in_ready;
   assign en4 = !s4_vld_ff || en5;
   assign en3 = !s3_vld_ff || en4;
   assign en2 = !s2_vld_ff || en3;
   assign en1 = !s1_vld_ff || en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         t6_vld_ff <= 1'b0;
         t7_vld_ff <= 1'b0;
      end else begin
         if (en1) s1_vld_ff <= req_tvalid;
         if (en2) s2_vld_ff <= s1_vld_ff;
         if (en3) s3_vld_ff <= s2_vld_ff;
         if (en4) s4_vld_ff <= s3_vld_ff;
         if (en5) s5_vld_ff <= s4_vld_ff;
         if (en6) t6_vld_ff <= sq_out_valid;
         if (en7) t7_vld_ff <= t6_vld_ff;
      end
   end

   assign req_tready   = en1;
   assign rsp_tvalid   = div_out_valid;
   assign rsp_tdata    = {div_quo[5], div_quo[4], div_quo[3],
                          div_quo[2], div_quo[1], div_quo[0]};
   assign rsp_tuser[0] = div_flag;

endmodule

// ===== sv/rmj_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on rmj_pkg.
module rmj_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [rmj_pkg::R2_W-1:0] in_r2,
   input  rmj_pkg::side_type      in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [rmj_pkg::R_W-1:0] out_root,
   output rmj_pkg::side_type      out_side
);
   import rmj_pkg::*;

   logic [R2_W-1:0] v_ff   [SQRT_STEPS];
   logic [R2_W-1:0] res_ff [SQRT_STEPS];
   side_type        side_ff [SQRT_STEPS];
   logic            vld_ff [SQRT_STEPS];
   logic            en     [SQRT_STEPS+1];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      localparam logic [R2_W-1:0] ONE_BIT = R2_W'(1) << (R2_W - 2 - 2 * i);
      logic [R2_W-1:0] v_src;
      logic [R2_W-1:0] res_src;
      logic [R2_W-1:0] trial;
      side_type        side_src;
      logic            vld_src;

      if (i == 0) begin : g_first
         assign v_src    = in_r2;
         assign res_src  = '0;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign v_src    = v_ff[i-1];
         assign res_src  = res_ff[i-1];
         assign side_src = side_ff[i-1];
         assign vld_src  = vld_ff[i-1];
      end

      assign trial = res_src + ONE_BIT;
      assign en[i] = !vld_ff[i] || en[i+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en[i]) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            if (v_src >= trial) begin
               v_ff[i]   <= v_src - trial;
               res_ff[i] <= (res_src >> 1) + ONE_BIT;
            end else begin
               v_ff[i]   <= v_src;
               res_ff[i] <= res_src >> 1;
            end
            side_ff[i] <= side_src;
         end
      end
   end

   assign en[SQRT_STEPS] = out_ready;
   assign in_ready       = en[0];
   assign out_valid      = vld_ff[SQRT_STEPS-1];
   assign out_root       = res_ff[SQRT_STEPS-1][R_W-1:0];
   assign out_side       = side_ff[SQRT_STEPS-1];

endmodule

// ===== sv/rmj_div.sv =====
// Six-lane pipelined saturating divider, one quotient bit per stage.
// Depends on rmj_pkg.
module rmj_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rmj_pkg::num_type          in_num [rmj_pkg::LANES],
   input  rmj_pkg::den_type          in_den [rmj_pkg::LANES],
   input  logic [rmj_pkg::LANES-1:0] in_neg,
   input  logic                      in_flag,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rmj_pkg::word_type         out_quo [rmj_pkg::LANES],
   output logic                      out_flag
);
   import rmj_pkg::*;

   localparam logic [DATA_W-1:0] POS_LIM = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_LIM = {1'b1, {(DATA_W-1){1'b0}}};

   // Stage 0 is the overflow check; stage k holds the state after quotient bit k.
   den_type           rem_ff [QUO_W+1][LANES];
   den_type           den_ff [QUO_W+1][LANES];
   logic [QUO_W-1:0]  low_ff [QUO_W+1][LANES];
   logic [QUO_W-1:0]  q_ff   [QUO_W+1][LANES];
   logic [LANES-1:0]  neg_ff [QUO_W+1];
   logic [LANES-1:0]  ovf_ff [QUO_W+1];
   logic [LANES-1:0]  dz_ff  [QUO_W+1];
   logic              flag_ff [QUO_W+1];
   logic              vld_ff [QUO_W+2];
   logic              en     [QUO_W+3];
   word_type          quo_ff [LANES];
   logic              oflag_ff;

   // Overflow check: the quotient needs more than QUO_W bits when num >= den * 2^QUO_W.
   logic [LANES-1:0] ovf_in;
   logic [LANES-1:0] dz_in;
   den_type          head [LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_pre
      assign head[l]   = DEN_W'(in_num[l][NUM_W-1:QUO_W]);
      assign ovf_in[l] = head[l] >= in_den[l];
      assign dz_in[l]  = in_den[l] == '0;

      always_ff @(posedge clock) begin
         if (en[0]) begin
            rem_ff[0][l] <= head[l];
            den_ff[0][l] <= in_den[l];
            low_ff[0][l] <= in_num[l][QUO_W-1:0];
            q_ff[0][l]   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg_ff[0]  <= in_neg;
         ovf_ff[0]  <= ovf_in;
         dz_ff[0]   <= dz_in;
         flag_ff[0] <= in_flag;
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DEN_W:0] trial;
         logic           fit;

         assign trial = {rem_ff[k-1][l], low_ff[k-1][l][QUO_W-1]};
         assign fit   = trial >= {1'b0, den_ff[k-1][l]};

         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k][l] <= fit ? DEN_W'(trial - {1'b0, den_ff[k-1][l]})
                                   : trial[DEN_W-1:0];
               den_ff[k][l] <= den_ff[k-1][l];
               low_ff[k][l] <= low_ff[k-1][l] << 1;
               q_ff[k][l]   <= {q_ff[k-1][l][QUO_W-2:0], fit};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            neg_ff[k]  <= neg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            dz_ff[k]   <= dz_ff[k-1];
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   // Final stage: clamp to the signed range and apply the sign; a zero divisor gives 0.
   for (genvar l = 0; l < LANES; l++) begin : g_sat
      logic [DATA_W-1:0] lim;
      logic [DATA_W-1:0] mag;

      assign lim = neg_ff[QUO_W][l] ? NEG_LIM : POS_LIM;
      assign mag = (ovf_ff[QUO_W][l] || q_ff[QUO_W][l] > lim) ? lim : q_ff[QUO_W][l];

      always_ff @(posedge clock) begin
         if (en[QUO_W+1]) begin
            if (dz_ff[QUO_W][l]) begin
               quo_ff[l] <= '0;
            end else if (neg_ff[QUO_W][l]) begin
               quo_ff[l] <= DATA_W'(0) - mag;
            end else begin
               quo_ff[l] <= mag;
            end
         end
      end

      assign out_quo[l] = quo_ff[l];
   end

   always_ff @(posedge clock) begin
      if (en[QUO_W+1]) begin
         oflag_ff <= flag_ff[QUO_W];
      end
   end

   for (genvar k = 0; k <= QUO_W + 1; k++) begin : g_vld
      assign en[k] = !vld_ff[k] || en[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en[k]) begin
            vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign en[QUO_W+2] = out_ready;
   assign in_ready    = en[0];
   assign out_valid   = vld_ff[QUO_W+1];
   assign out_flag    = oflag_ff;

endmodule

// ===== tb/sv/radar_measurement_jacobian_tb.sv =====
// Self-checking testbench for the radar measurement Jacobian pipeline.
// Depends on rmj_pkg and radar_measurement_jacobian; streams random and corner
// state vectors through the block and checks every result word against a predictor.
module radar_measurement_jacobian_tb;
   import rmj_pkg::*;

   // One expected result word: six Jacobian entries and the near-zero flag.
   typedef struct {
      logic [31:0] jac [6];
      logic        near_zero;
   } jacobian_type;

   logic         clock;
   logic         reset;
   logic         csr_wen;
   logic [31:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;    // pos_x, pos_y, vel_x, vel_y
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [191:0] rsp_tdata;    // range_by_px, range_by_py, bearing_by_px,
                               // bearing_by_py, rate_by_px, rate_by_py
   logic [0:0]   rsp_tuser;    // near_zero

   // The pending state vectors, the results still owed by the block, and the
   // guard value that the predictor keeps in step with the register.
   logic [127:0] state_queue [$];
   jacobian_type jacobian_queue [$];
   logic [31:0]  guard_model;
   int           error_count;
   int           sent_count;
   int           burst_left;
   int           gap_left;
   int           hold_left;
   bit           hold_done;

   string field_names [6] = '{"range_by_px", "range_by_py", "bearing_by_px",
                              "bearing_by_py", "rate_by_px", "rate_by_py"};

   radar_measurement_jacobian u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Integer square root, rounded down, of a 64-bit value.
   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_mask;
      res = '0;
      bit_mask = 64'd1 << 62;
      while (bit_mask > v) bit_mask = bit_mask >> 2;
      while (bit_mask != 0) begin
         if (v >= res + bit_mask) begin
            v = v - (res + bit_mask);
            res = (res >> 1) + bit_mask;
         end else begin
            res = res >> 1;
         end
         bit_mask = bit_mask >> 2;
      end
      return res;
   endfunction

   // Truncating division with saturation to signed 32 bits; a zero divisor gives 0.
   function automatic logic [31:0] sat_quotient(bit neg, logic [127:0] num,
                                                logic [127:0] den);
      logic [127:0] q;
      logic [127:0] lim;
      if (den == 0) return 32'd0;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      q = num / den;
      if (q > lim) q = lim;
      if (neg) q = -q;
      return q[31:0];
   endfunction

   // Works out the Jacobian entries for one state vector under the current guard.
   function automatic jacobian_type jacobian_of(logic [127:0] word);
      jacobian_type res;
      logic signed [63:0] px, py, vx, vy, prod_a, prod_b;
      logic [63:0]  apx, apy, r2, r, cmag;
      logic [127:0] r3;
      bit           cneg;
      px = $signed(word[31:0]);
      py = $signed(word[63:32]);
      vx = $signed(word[95:64]);
      vy = $signed(word[127:96]);
      apx = (px < 0) ? -px : px;
      apy = (py < 0) ? -py : py;
      r2 = apx * apx + apy * apy;
      res.near_zero = 1'b0;
      // Below the guard the squared range is taken as exactly one.
      if (r2 < {32'd0, guard_model}) begin
         r2 = 64'd1 << (2 * FRAC_BITS);
         res.near_zero = 1'b1;
      end
      r = floor_sqrt(r2);
      r3 = {64'd0, r2} * {64'd0, r};
      prod_a = vx * py;
      prod_b = vy * px;
      cneg = prod_a < prod_b;
      cmag = cneg ? prod_b - prod_a : prod_a - prod_b;
      res.jac[0] = sat_quotient(px < 0, {64'd0, apx} << FRAC_BITS, {64'd0, r});
      res.jac[1] = sat_quotient(py < 0, {64'd0, apy} << FRAC_BITS, {64'd0, r});
      res.jac[2] = sat_quotient(py > 0, {64'd0, apy} << (2 * FRAC_BITS), {64'd0, r2});
      res.jac[3] = sat_quotient(px < 0, {64'd0, apx} << (2 * FRAC_BITS), {64'd0, r2});
      res.jac[4] = sat_quotient((py < 0) != cneg,
                                ({64'd0, apy} * {64'd0, cmag}) << FRAC_BITS, r3);
      res.jac[5] = sat_quotient((px < 0) == cneg,
                                ({64'd0, apx} * {64'd0, cmag}) << FRAC_BITS, r3);
      return res;
   endfunction

   // A random field value: full range, a small magnitude, or an extreme.
   function automatic logic [31:0] random_field();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom;
         2, 3: v = $urandom >> $urandom_range(8, 31);
         4: v = -($urandom >> $urandom_range(8, 31));
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'd0;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic logic [127:0] pack_state(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] vx, logic [31:0] vy);
      return {vy, vx, py, px};
   endfunction

   // Driver: bursts of random length with random gaps. At each accepted word the
   // prediction is made, since the guard never changes while words are in flight.
   // A word that is offered stays unchanged until the block takes it.
   always @(posedge clock) begin
      bit next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (req_tvalid && !req_tready) begin
         req_tvalid <= 1'b1;
      end else begin
         if (req_tvalid && req_tready) begin
            jacobian_queue.push_back(jacobian_of(req_tdata));
            void'(state_queue.pop_front());
            sent_count <= sent_count + 1;
         end
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (state_queue.size() > 0) begin
            next_valid = 1'b1;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 40);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         req_tvalid <= next_valid;
         if (next_valid) req_tdata <= state_queue[0];
      end
   end

   // Monitor: random stalls, one long hold-off midway so the pipeline fills up
   // and pushes back on req_tready, and a field-by-field check of every word.
   always @(posedge clock) begin
      jacobian_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (jacobian_queue.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               error_count = error_count + 1;
            end else begin
               want = jacobian_queue.pop_front();
               for (int i = 0; i < 6; i++) begin
                  if (rsp_tdata[32*i +: 32] !== want.jac[i]) begin
                     $error("%s: expected %h, got %h", field_names[i], want.jac[i],
                            rsp_tdata[32*i +: 32]);
                     error_count = error_count + 1;
                  end
               end
               if (rsp_tuser[0] !== want.near_zero) begin
                  $error("near_zero: expected %b, got %b", want.near_zero, rsp_tuser[0]);
                  error_count = error_count + 1;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && sent_count > 400) begin
            hold_done  <= 1'b1;
            hold_left  <= 300;
            rsp_tready <= 1'b0;
         end else begin
            // Stall pattern: long ready stretches mixed with choppy ones.
            rsp_tready <= (sent_count % 200 < 60) ? 1'b1 : ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Waits until every owed result has come back and the pipe has drained.
   task automatic drain_pipeline();
      while (state_queue.size() > 0 || jacobian_queue.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_guard(logic [31:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      guard_model = value;
      @(posedge clock);
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         state_queue.push_back(pack_state(random_field(), random_field(),
                                          random_field(), random_field()));
   endtask

   initial begin
      logic [31:0] guard_list [5];
      reset       = 1'b1;
      csr_wen     = 1'b0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      error_count = 0;
      sent_count  = 0;
      guard_model = GUARD_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset guard: zero state, extremes, states just
      // inside and outside the guard, and ones that saturate the bearing terms.
      state_queue.push_back(pack_state(0, 0, 0, 0));
      state_queue.push_back(pack_state(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF));
      state_queue.push_back(pack_state(32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 32'h8000_0000));
      state_queue.push_back(pack_state(32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 32'h8000_0000));
      state_queue.push_back(pack_state(32'h0001_0000, 0, 32'h0001_0000, 0));
      state_queue.push_back(pack_state(0, 32'hFFFF_0000, 0, 32'h0002_0000));
      state_queue.push_back(pack_state(1, 0, 32'h7FFF_FFFF, 32'h8000_0000));
      state_queue.push_back(pack_state(0, 32'hFFFF_FFFF, 32'h8000_0000, 5));
      state_queue.push_back(pack_state(655, 0, 32'h0003_0000, 32'hFFFD_0000));
      state_queue.push_back(pack_state(656, 0, 32'h0003_0000, 32'hFFFD_0000));
      state_queue.push_back(pack_state(32'h0000_0100, 32'hFFFF_FF00, 32'h1000_0000,
                                       32'h1000_0000));
      state_queue.push_back(pack_state(32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000,
                                       32'h0002_8000));
      queue_random(250);
      drain_pipeline();

      // Each later phase writes a new guard, starting at the extremes and ending at
      // the default. The zero guard phase starts with a zero position, where every
      // division has a zero divisor.
      guard_list = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom >> 8, GUARD_RESET};
      foreach (guard_list[p]) begin
         write_guard(guard_list[p]);
         if (p == 0) begin
            state_queue.push_back(pack_state(0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
            state_queue.push_back(pack_state(1, 0, 0, 0));
         end
         queue_random(210);
         drain_pipeline();
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
